### design/isotp_rx_pkg.sv
// Shared types and constants for the ISO-TP segmented frame receiver.
// Holds the item structs, status and frame type codes and the session state record.
// No dependencies.
`default_nettype none

package isotp_rx_pkg;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned MSGLEN_W  = 12;
    localparam int unsigned FCNT_W    = 10;
    localparam int unsigned BEFORE_W  = 13;

    localparam logic [ID_W-1:0]     BASE_ID_RESET = 11'd2024;
    localparam logic [ID_W:0]       ID_WINDOW_TOP = 12'd7;
    localparam logic [ID_W-1:0]     FC_ID_OFFSET  = 11'd8;
    localparam logic [LEN_W-1:0]    MAX_LEN       = 4'd8;
    localparam logic [LEN_W-1:0]    MIN_LEN       = 4'd3;
    localparam logic [LEN_W-1:0]    SF_MAX_COUNT  = 4'd7;
    localparam logic [LEN_W-1:0]    FF_MAX_COUNT  = 4'd6;
    localparam logic [LEN_W-1:0]    CF_MAX_COUNT  = 4'd7;
    localparam logic [MSGLEN_W-1:0] FF_BYTES      = 12'd6;
    localparam logic [BEFORE_W-1:0] FF_BYTES_EXT  = 13'd6;
    localparam logic [BEFORE_W-1:0] CF_BYTES      = 13'd7;
    // floor(x / 7) = (x * 2341) >> 14 for every 12-bit x
    localparam logic [23:0]         RECIP_7       = 24'd2341;
    localparam int unsigned         RECIP_SHIFT   = 14;

    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    localparam logic [STATUS_W-1:0] ST_SINGLE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONSECUTIVE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ID      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_SEQ     = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte_0;
        logic [BYTE_W-1:0] data_byte_1;
        logic [BYTE_W-1:0] data_byte_2;
        logic [BYTE_W-1:0] data_byte_3;
        logic [BYTE_W-1:0] data_byte_4;
        logic [BYTE_W-1:0] data_byte_5;
        logic [BYTE_W-1:0] data_byte_6;
        logic [BYTE_W-1:0] data_byte_7;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  payload_count;
        logic [BYTE_W-1:0]   payload_0;
        logic [BYTE_W-1:0]   payload_1;
        logic [BYTE_W-1:0]   payload_2;
        logic [BYTE_W-1:0]   payload_3;
        logic [BYTE_W-1:0]   payload_4;
        logic [BYTE_W-1:0]   payload_5;
        logic [BYTE_W-1:0]   payload_6;
        logic                flow_control_send;
        logic [ID_W-1:0]     flow_control_id;
        logic [MSGLEN_W-1:0] message_length;
    } out_item_t;

    // bytes_before: message bytes delivered ahead of the next consecutive frame
    typedef struct packed {
        logic                collecting;
        logic [FCNT_W-1:0]   frame_counter;
        logic [FCNT_W-1:0]   frames_needed;
        logic [MSGLEN_W-1:0] total_length;
        logic [BEFORE_W-1:0] bytes_before;
    } rx_state_t;

endpackage

`default_nettype wire

### design/isotp_segmented_frame_receiver_core.sv
// ISO-TP segmented frame receiver, top level. The result is registered at the accepting edge.
// Throughput: one item per cycle while m_ready is high; the result register frees as the item is taken.
// Session state updates at the accepting edge, so the next item sees it at once.
// Reset (aresetn low, synchronous): idle session, empty result register, base id 2024.
// Depends on isotp_rx_pkg and isotp_rx_decode.
`default_nettype none

module isotp_segmented_frame_receiver_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [10:0]                   cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire isotp_rx_pkg::in_item_t  s_item,
    output logic                         m_valid,
    input  wire                          m_ready,
    output isotp_rx_pkg::out_item_t      m_item
);
    import isotp_rx_pkg::*;

    logic [ID_W-1:0] base_id_reg;
    rx_state_t       state_reg;
    rx_state_t       state_next;
    out_item_t       result_next;
    out_item_t       m_item_reg;
    logic            m_valid_reg;
    logic            accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    isotp_rx_decode u_decode (
        .in_item    (s_item),
        .state      (state_reg),
        .base_id    (base_id_reg),
        .out_item   (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg <= BASE_ID_RESET;
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_id_reg <= cfg_wr_data;
            end
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

### design/isotp_rx_decode.sv
// Combinational frame decoder: window and length checks, PCI classification,
// payload extraction and next session state. Depends on isotp_rx_pkg.
`default_nettype none

module isotp_rx_decode (
    input  wire isotp_rx_pkg::in_item_t   in_item,
    input  wire isotp_rx_pkg::rx_state_t  state,
    input  wire [10:0]                    base_id,
    output isotp_rx_pkg::out_item_t       out_item,
    output isotp_rx_pkg::rx_state_t       state_next
);
    import isotp_rx_pkg::*;

    logic [BYTE_W-1:0]   data [8];
    logic [BYTE_W-1:0]   pay [7];
    logic [LEN_W-1:0]    len_c;
    logic [LEN_W-1:0]    len_m1;
    logic [LEN_W-1:0]    len_m2;
    logic [ID_W:0]       id_ext;
    logic [ID_W:0]       base_ext;
    logic                in_window;
    logic [3:0]          pci_type;
    logic [3:0]          pci_low;
    logic [LEN_W-1:0]    cnt4;
    logic [COUNT_W-1:0]  cnt;
    logic                from_byte2;
    logic [MSGLEN_W-1:0] ff_len;
    logic [23:0]         ff_prod;
    logic [FCNT_W-1:0]   ff_frames;
    logic [FCNT_W-1:0]   fc_new;
    logic [BEFORE_W-1:0] tl_ext;
    logic [BEFORE_W-1:0] remain;

    always_comb begin
        data[0] = in_item.data_byte_0;
        data[1] = in_item.data_byte_1;
        data[2] = in_item.data_byte_2;
        data[3] = in_item.data_byte_3;
        data[4] = in_item.data_byte_4;
        data[5] = in_item.data_byte_5;
        data[6] = in_item.data_byte_6;
        data[7] = in_item.data_byte_7;

        len_c     = (in_item.frame_length > MAX_LEN) ? MAX_LEN : in_item.frame_length;
        len_m1    = len_c - 4'd1;
        len_m2    = len_c - 4'd2;
        id_ext    = {1'b0, in_item.frame_id};
        base_ext  = {1'b0, base_id};
        in_window = (id_ext >= base_ext) && (id_ext <= base_ext + ID_WINDOW_TOP);
        pci_type  = data[0][7:4];
        pci_low   = data[0][3:0];

        ff_len    = {pci_low, data[1]};
        ff_prod   = {12'd0, ff_len} * RECIP_7;
        ff_frames = (ff_len <= FF_BYTES) ? '0 : ff_prod[RECIP_SHIFT +: FCNT_W];
        fc_new    = state.frame_counter + 10'd1;
        tl_ext    = {1'b0, state.total_length};
        remain    = (tl_ext > state.bytes_before) ? tl_ext - state.bytes_before : '0;

        out_item   = '0;
        state_next = state;
        cnt4       = '0;
        from_byte2 = 1'b0;

        priority if (!in_window) begin
            out_item.status = ST_BAD_ID;
        end else if (len_c < MIN_LEN) begin
            out_item.status = ST_SHORT;
        end else if (pci_type == PCI_SINGLE) begin
            cnt4 = (pci_low < len_m1) ? pci_low : len_m1;
            if (cnt4 > SF_MAX_COUNT) begin
                cnt4 = SF_MAX_COUNT;
            end
            out_item.status         = ST_SINGLE;
            out_item.message_length = {8'd0, cnt4};
        end else if (!state.collecting) begin
            if (pci_type != PCI_FIRST) begin
                out_item.status = ST_UNEXPECTED;
            end else begin
                cnt4 = (len_m2 < FF_MAX_COUNT) ? len_m2 : FF_MAX_COUNT;
                if ({8'd0, cnt4} > ff_len) begin
                    cnt4 = ff_len[LEN_W-1:0];
                end
                from_byte2                 = 1'b1;
                out_item.status            = ST_FIRST;
                out_item.flow_control_send = 1'b1;
                out_item.flow_control_id   = in_item.frame_id - FC_ID_OFFSET;
                out_item.message_length    = ff_len;
                state_next.collecting      = 1'b1;
                state_next.frame_counter   = '0;
                state_next.frames_needed   = ff_frames;
                state_next.total_length    = ff_len;
                state_next.bytes_before    = FF_BYTES_EXT;
            end
        end else begin
            state_next.frame_counter = fc_new;
            if (pci_type != PCI_CONSECUTIVE) begin
                state_next.collecting = 1'b0;
                out_item.status       = ST_UNEXPECTED;
            end else if (pci_low != fc_new[3:0]) begin
                state_next.collecting = 1'b0;
                out_item.status       = ST_BAD_SEQ;
            end else begin
                cnt4 = (len_m1 < CF_MAX_COUNT) ? len_m1 : CF_MAX_COUNT;
                if ({9'd0, cnt4} > remain) begin
                    cnt4 = remain[LEN_W-1:0];
                end
                out_item.message_length = state.total_length;
                state_next.bytes_before = state.bytes_before + CF_BYTES;
                if (fc_new >= state.frames_needed) begin
                    state_next.collecting = 1'b0;
                    out_item.status       = ST_COMPLETE;
                end else begin
                    out_item.status = ST_CONSECUTIVE;
                end
            end
        end

        cnt                    = cnt4[COUNT_W-1:0];
        out_item.payload_count = cnt;

        for (int k = 0; k < 7; k++) begin
            pay[k] = '0;
            if (k < 32'(cnt)) begin
                if (!from_byte2) begin
                    pay[k] = data[k+1];
                end else if (k < 6) begin
                    pay[k] = data[(k+2) % 8];
                end
            end
        end
        out_item.payload_0 = pay[0];
        out_item.payload_1 = pay[1];
        out_item.payload_2 = pay[2];
        out_item.payload_3 = pay[3];
        out_item.payload_4 = pay[4];
        out_item.payload_5 = pay[5];
        out_item.payload_6 = pay[6];
    end

endmodule

`default_nettype wire

### design/isotp_rx_checker.sv
// Port-level checker for the ISO-TP receiver and its bind to the top level.
// Depends on isotp_rx_pkg and isotp_segmented_frame_receiver_core.
`default_nettype none

module isotp_rx_checker (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           m_valid,
    input  wire                           m_ready,
    input  wire isotp_rx_pkg::out_item_t  m_item
);
    import isotp_rx_pkg::*;

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fc_with_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.flow_control_send == (m_item.status == ST_FIRST)))
        else $error("flow control request without first frame");

    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == ST_BAD_ID || m_item.status == ST_SHORT ||
                    m_item.status == ST_UNEXPECTED || m_item.status == ST_BAD_SEQ)
        |-> m_item.payload_count == '0 && m_item.message_length == '0)
        else $error("error result carries data");

    a_single_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == ST_SINGLE
        |-> m_item.message_length == {9'd0, m_item.payload_count})
        else $error("single frame length mismatch");

endmodule

bind isotp_segmented_frame_receiver_core isotp_rx_checker u_isotp_rx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

### test/tb_isotp_segmented_frame_receiver_core.sv
// Testbench for isotp_segmented_frame_receiver_core: directed frame table, then random
// ISO-TP sessions under random stalls, each result checked against a pinned value or a local decoder.
// Depends on isotp_rx_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_isotp_segmented_frame_receiver_core;

    import isotp_rx_pkg::*;

    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 3;

    typedef struct {
        in_item_t  frame;
        bit        pinned;
        out_item_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_item      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_item;

    // decoder copy of the session and the id window
    int unsigned    base_id     = BASE_ID_RESET;
    logic           sess_active = 1'b0;
    logic [9:0]     cf_count    = '0;
    logic [9:0]     cf_needed   = '0;
    logic [11:0]    msg_total   = '0;

    out_item_t   awaited_results [$];
    in_item_t    frame_plan [$];
    stim_row_t   stim_table [$];
    int unsigned fail_count   = 0;
    int          send_quiet   = 0;
    int          recv_quiet   = 0;
    int          rush_left    = 0;
    bit          hold_off_req = 1'b0;

    isotp_segmented_frame_receiver_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int draw_wait(ref int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic out_item_t status_only(input logic [STATUS_W-1:0] st);
        out_item_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic out_item_t decode_frame(input in_item_t f);
        out_item_t   r;
        logic [7:0]  fb [0:7];
        logic [7:0]  pay [0:6];
        logic [3:0]  kind;
        logic [3:0]  low;
        int unsigned len, first, cnt, sent_bytes, remain, need, k;
        r = '0;
        fb[0] = f.data_byte_0;
        fb[1] = f.data_byte_1;
        fb[2] = f.data_byte_2;
        fb[3] = f.data_byte_3;
        fb[4] = f.data_byte_4;
        fb[5] = f.data_byte_5;
        fb[6] = f.data_byte_6;
        fb[7] = f.data_byte_7;
        for (k = 0; k < 7; k++) pay[k] = '0;
        len = (f.frame_length > MAX_LEN) ? MAX_LEN : f.frame_length;
        if (f.frame_id < base_id || f.frame_id > base_id + 7) begin
            r.status = ST_BAD_ID;
            return r;
        end
        if (len < MIN_LEN) begin
            r.status = ST_SHORT;
            return r;
        end
        kind  = fb[0][7:4];
        low   = fb[0][3:0];
        first = 1;
        cnt   = 0;
        if (kind == PCI_SINGLE) begin
            cnt = lesser(lesser(low, len - 1), SF_MAX_COUNT);
            r.status = ST_SINGLE;
            r.message_length = cnt[11:0];
        end else if (!sess_active) begin
            if (kind != PCI_FIRST) begin
                r.status = ST_UNEXPECTED;
                return r;
            end
            msg_total   = {low, fb[1]};
            need        = msg_total / 7;
            cf_needed   = need[9:0];
            cf_count    = '0;
            sess_active = 1'b1;
            first = 2;
            cnt   = lesser(lesser(FF_MAX_COUNT, len - 2), msg_total);
            r.status            = ST_FIRST;
            r.flow_control_send = 1'b1;
            r.flow_control_id   = f.frame_id - FC_ID_OFFSET;
            r.message_length    = msg_total;
        end else begin
            cf_count = cf_count + 1'b1;
            if (kind != PCI_CONSECUTIVE) begin
                sess_active = 1'b0;
                r.status = ST_UNEXPECTED;
                return r;
            end
            if (low != cf_count[3:0]) begin
                sess_active = 1'b0;
                r.status = ST_BAD_SEQ;
                return r;
            end
            sent_bytes = 6 + 7 * (cf_count - 1);
            remain = (msg_total > sent_bytes) ? msg_total - sent_bytes : 0;
            cnt    = lesser(lesser(CF_MAX_COUNT, len - 1), remain);
            r.message_length = msg_total;
            if (cf_count >= cf_needed) begin
                sess_active = 1'b0;
                r.status = ST_COMPLETE;
            end else begin
                r.status = ST_CONSECUTIVE;
            end
        end
        for (k = 0; k < cnt && k < 7 && first + k < 8; k++) pay[k] = fb[first + k];
        r.payload_count = cnt[2:0];
        r.payload_0 = pay[0];
        r.payload_1 = pay[1];
        r.payload_2 = pay[2];
        r.payload_3 = pay[3];
        r.payload_4 = pay[4];
        r.payload_5 = pay[5];
        r.payload_6 = pay[6];
        return r;
    endfunction

    task automatic report(input string msg);
        fail_count++;
        $display("%0t %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
    endtask

    task automatic compare_result(input out_item_t want, input out_item_t got);
        check_field("status", want.status, got.status);
        check_field("payload_count", want.payload_count, got.payload_count);
        check_field("payload_0", want.payload_0, got.payload_0);
        check_field("payload_1", want.payload_1, got.payload_1);
        check_field("payload_2", want.payload_2, got.payload_2);
        check_field("payload_3", want.payload_3, got.payload_3);
        check_field("payload_4", want.payload_4, got.payload_4);
        check_field("payload_5", want.payload_5, got.payload_5);
        check_field("payload_6", want.payload_6, got.payload_6);
        check_field("flow_control_send", want.flow_control_send, got.flow_control_send);
        check_field("flow_control_id", want.flow_control_id, got.flow_control_id);
        check_field("message_length", want.message_length, got.message_length);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (awaited_results.size() == 0)
                report($sformatf("result with none expected: expected none, actual %h",
                                 m_item));
            else
                compare_result(awaited_results.pop_front(), m_item);
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = draw_wait(recv_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic send_frame(input in_item_t f, input bit pinned, input out_item_t want);
        int        gap;
        out_item_t pred;
        if (rush_left > 0) begin
            rush_left--;
            gap = 0;
        end else begin
            gap = draw_wait(send_quiet);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= f;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = decode_frame(f);
        awaited_results = {awaited_results, (pinned ? want : pred)};
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_base(input logic [10:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_id = v;
    endtask

    task automatic add_row(input logic [10:0] id, input logic [3:0] len,
                           input logic [63:0] bytes, input bit pinned,
                           input out_item_t want);
        stim_row_t row;
        row.frame  = {id, len, bytes};
        row.pinned = pinned;
        row.want   = want;
        stim_table = {stim_table, row};
    endtask

    function automatic in_item_t rand_frame(input logic [7:0] pci, input bit in_window);
        logic [63:0] raw;
        int unsigned id, lv, sel;
        raw = {$urandom, $urandom};
        if (in_window) begin
            id = base_id + $urandom_range(0, 7);
        end else begin
            id = $urandom_range(0, 2047);
            if (id >= base_id && id <= base_id + 7)
                id = (base_id + 8 + $urandom_range(0, 2031)) % 2048;
        end
        sel = $urandom_range(0, 9);
        if (sel < 6)      lv = 8;
        else if (sel < 8) lv = $urandom_range(3, 8);
        else              lv = $urandom_range(0, 15);
        return {id[10:0], lv[3:0], pci, raw[55:0]};
    endfunction

    task automatic plan_noise();
        logic [7:0] pci;
        pci = 8'($urandom_range(0, 255));
        frame_plan = {frame_plan, rand_frame(pci, $urandom_range(0, 3) != 0)};
    endtask

    task automatic plan_message();
        in_item_t    f;
        int unsigned total, n_cf, k, sel, wrong;
        sel = $urandom_range(0, 19);
        if (sel < 3)       total = $urandom_range(0, 6);
        else if (sel < 15) total = $urandom_range(7, 60);
        else if (sel < 19) total = $urandom_range(100, 260);
        else               total = $urandom_range(261, 4095);
        n_cf = total / 7;
        if (n_cf == 0) n_cf = 1;
        // cut very long messages short
        if (n_cf > 40) n_cf = $urandom_range(1, 20);
        f = rand_frame({PCI_FIRST, total[11:8]}, 1'b1);
        f.data_byte_1 = total[7:0];
        frame_plan = {frame_plan, f};
        for (k = 1; k <= n_cf; k++) begin
            sel = $urandom_range(0, 39);
            if (sel == 0) begin
                frame_plan = {frame_plan, rand_frame(8'h00, 1'b0)};
            end else if (sel == 1) begin
                wrong = k + $urandom_range(1, 15);
                frame_plan = {frame_plan, rand_frame({PCI_CONSECUTIVE, wrong[3:0]}, 1'b1)};
                return;
            end else if (sel == 2) begin
                plan_noise();
                return;
            end
            frame_plan = {frame_plan, rand_frame({PCI_CONSECUTIVE, k[3:0]}, 1'b1)};
        end
    endtask

    task automatic plan_phase(input int n);
        int unsigned sel, low;
        while (frame_plan.size() < n) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                plan_message();
            end else if (sel < 8) begin
                low = $urandom_range(0, 15);
                frame_plan = {frame_plan, rand_frame({PCI_SINGLE, low[3:0]}, 1'b1)};
            end else begin
                plan_noise();
            end
        end
    endtask

    initial begin : stimulus
        logic [10:0] phase_base [0:3];
        stim_row_t   row;
        int          p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(11'd2023, 4'd8,  64'h02AA_BB00_0000_0000, 1'b1, status_only(ST_BAD_ID));
        add_row(11'd2032, 4'd8,  64'h02AA_BB00_0000_0000, 1'b1, status_only(ST_BAD_ID));
        add_row(11'd2031, 4'd2,  64'h0312_3456_7890_ABCD, 1'b1, status_only(ST_SHORT));
        add_row(11'd2024, 4'd0,  64'h0312_3456_7890_ABCD, 1'b1, status_only(ST_SHORT));
        add_row(11'd2024, 4'd8,  64'h0711_2233_4455_6677, 1'b1,
                out_item_t'({ST_SINGLE, 3'd7, 56'h11_2233_4455_6677, 1'b0, 11'd0, 12'd7}));
        add_row(11'd2031, 4'd15, 64'h0FFF_FFFF_FFFF_FFFF, 1'b0, '0);
        add_row(11'd2025, 4'd3,  64'h00FF_0000_0000_0000, 1'b0, '0);
        add_row(11'd2024, 4'd8,  64'h2101_0203_0405_0607, 1'b1, status_only(ST_UNEXPECTED));
        add_row(11'd2024, 4'd8,  64'hF000_0000_0000_0000, 1'b1, status_only(ST_UNEXPECTED));
        add_row(11'd2024, 4'd8,  64'h1FFF_0102_0304_0506, 1'b0, '0);
        add_row(11'd2024, 4'd8,  64'h2100_FF00_FF00_FF00, 1'b0, '0);
        add_row(11'd2026, 4'd8,  64'h1020_0000_0000_0000, 1'b1, status_only(ST_UNEXPECTED));
        add_row(11'd2024, 4'd8,  64'h1003_A1A2_A3A4_A5A6, 1'b0, '0);
        add_row(11'd2024, 4'd8,  64'h21B1_B2B3_B4B5_B6B7, 1'b0, '0);
        add_row(11'd2027, 4'd8,  64'h1014_C1C2_C3C4_C5C6, 1'b0, '0);
        add_row(11'd2027, 4'd8,  64'h21D1_D2D3_D4D5_D6D7, 1'b0, '0);
        add_row(11'd2027, 4'd8,  64'h23E1_E2E3_E4E5_E6E7, 1'b1, status_only(ST_BAD_SEQ));
        add_row(11'd2028, 4'd8,  64'h1014_1112_1314_1516, 1'b0, '0);
        add_row(11'd2028, 4'd4,  64'h2121_2223_2425_2627, 1'b0, '0);
        add_row(11'd2028, 4'd8,  64'h2231_3233_3435_3637, 1'b0, '0);
        add_row(11'd2029, 4'd8,  64'h1000_4142_4344_4546, 1'b0, '0);
        add_row(11'd2029, 4'd8,  64'h2051_5253_5455_5657, 1'b1, status_only(ST_BAD_SEQ));
        add_row(11'd2030, 4'd8,  64'h1040_6162_6364_6566, 1'b0, '0);
        add_row(11'd2030, 4'd8,  64'h0371_7273_7475_7677, 1'b0, '0);
        add_row(11'd2030, 4'd8,  64'h2181_8283_8485_8687, 1'b0, '0);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            send_frame(row.frame, row.pinned, row.want);
        end
        settle();

        phase_base[0] = 11'd0;
        phase_base[1] = 11'd2040;
        phase_base[2] = 11'($urandom_range(0, 2040));
        phase_base[3] = 11'($urandom_range(0, 2040));
        for (p = 0; p < 4; p++) begin
            set_base(phase_base[p]);
            plan_phase(PHASE_ITEMS);
            // hold the sink off while frames keep coming, so the core backs up
            if (p == 1) begin
                hold_off_req = 1'b1;
                rush_left    = 40;
            end
            while (frame_plan.size() != 0) send_frame(frame_plan.pop_front(), 1'b0, '0);
            settle();
        end

        if (fail_count == 0) begin
            $display("[isotp_segmented_frame_receiver_core] OK");
        end else begin
            $display("[isotp_segmented_frame_receiver_core] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[isotp_segmented_frame_receiver_core] ERROR");
        $finish;
    end

endmodule
